@@ hw/rtl/itoa_pkg.sv @@
// Package for the integer-to-ASCII formatter: widths, character codes,
// divide-by-ten reciprocal and the sequencer state type.
// No dependencies.
package itoa_pkg;

	localparam int ValueW     = 32;
	localparam int PadW       = 4;
	localparam int CharW      = 8;
	localparam int DigitW     = 4;
	localparam int MaxDigits  = 10;
	localparam int CntW       = 4;
	localparam int InTdataW   = 40;
	localparam int ProdW      = 2 * ValueW;
	localparam int RecipShift = 35;

	localparam logic [PadW-1:0]   MaxPad    = 4'd9;
	localparam logic [ValueW-1:0] Recip10   = 32'hCCCC_CCCD;
	localparam logic [DigitW-1:0] DecBase   = 4'd10;
	localparam logic [CharW-1:0]  CharZero  = 8'h30;
	localparam logic [CharW-1:0]  CharA     = 8'h61;
	localparam logic [CharW-1:0]  CharMinus = 8'h2d;
	localparam logic [CharW-1:0]  CharSpace = 8'h20;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_DIV,
		S_SIZE,
		S_SPACE,
		S_SIGN,
		S_ZERO,
		S_DIGIT
	} fmt_state_t;

endpackage

@@ hw/rtl/int_to_ascii_formatter.sv @@
// Integer-to-ASCII formatter: signed 32-bit value to decimal or lower-case hex
// text, left padded with spaces or zeros. Depends on itoa_pkg.
//
// Sequence: after accepting an item, a quotient preload state, then one digit per step through the shared
// divide unit (reciprocal multiply for base ten, shift for base sixteen), a sizing state, then one
// character per cycle while the output is taken.
// A new item is accepted only when the sequencer is back in idle after its last character.
// Reset: arst_n clears the sequencer and output valid; the block then idles.
module int_to_ascii_formatter
	import itoa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// s_tdata: value[31:0], use_hex[32], pad_width[36:33], pad_zero[37], zeros
	input  logic [InTdataW-1:0] s_tdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// m_tdata: char_out[7:0]
	output logic [CharW-1:0]    m_tdata,
	output logic                m_tvalid,
	output logic                m_tlast,
	input  logic                m_tready
);

	fmt_state_t state_q, state_d;

	logic [ValueW-1:0] dividend_q;
	logic [ValueW-1:0] quot_q;
	logic              neg_q;
	logic              hex_q;
	logic              pad_zero_q;
	logic [PadW-1:0]   width_q;
	logic [PadW-1:0]   pad_q;
	logic [CntW-1:0]   nd_q;
	logic [DigitW-1:0] digit_q [MaxDigits];

	logic              m_tvalid_q;
	logic [CharW-1:0]  m_tdata_q;
	logic              m_tlast_q;

	logic              out_free;
	logic              load_in;
	logic              div_step;
	logic              size_step;
	logic              emit_fire;
	logic              pad_dec;
	logic              digit_pop;
	logic [CharW-1:0]  emit_char;
	logic              emit_last;

	logic [ValueW-1:0] div_in;
	logic [ProdW-1:0]  prod;
	logic [ValueW-1:0] div_out;
	logic [DigitW-1:0] q_times10;
	logic [DigitW-1:0] new_digit;
	logic [CntW-1:0]   text_len;
	logic [PadW-1:0]   pad_calc;
	logic [ValueW-1:0] in_value;
	logic [PadW-1:0]   in_width;
	logic [CharW-1:0]  digit_char;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Unpack the input transaction
	assign in_value = s_tdata[31:0];
	assign in_width = s_tdata[36:33];

	// Shared divide unit: quotient by the base
	assign div_in  = (state_q == S_FIRST) ? dividend_q : quot_q;
	assign prod    = div_in * Recip10;
	assign div_out = hex_q ? {4'b0000, div_in[ValueW-1:4]}
	                       : {3'b000, prod[ProdW-1:RecipShift]};

	// Remainder needs only the low nibble: x - 10*q modulo sixteen
	assign q_times10 = {quot_q[2:0], 1'b0} + {quot_q[0], 3'b000};
	assign new_digit = hex_q ? dividend_q[DigitW-1:0]
	                         : dividend_q[DigitW-1:0] - q_times10;

	// Field size and padding
	assign text_len = nd_q + {{(CntW-1){1'b0}}, neg_q};
	assign pad_calc = (width_q > text_len) ? (width_q - text_len) : '0;

	// Top digit as ASCII
	assign digit_char = (digit_q[0] < DecBase)
		? (CharZero + {4'b0000, digit_q[0]})
		: (CharA + {4'b0000, digit_q[0]} - {4'b0000, DecBase});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_FIRST;
			end
			S_FIRST: state_d = S_DIV;
			S_DIV: begin
				if (quot_q == '0) state_d = S_SIZE;
			end
			S_SIZE: begin
				if (pad_calc != '0 && !pad_zero_q) state_d = S_SPACE;
				else if (neg_q)                    state_d = S_SIGN;
				else if (pad_calc != '0)           state_d = S_ZERO;
				else                               state_d = S_DIGIT;
			end
			S_SPACE: begin
				if (out_free && pad_q == 4'd1) state_d = neg_q ? S_SIGN : S_DIGIT;
			end
			S_SIGN: begin
				if (out_free) state_d = (pad_zero_q && pad_q != '0) ? S_ZERO : S_DIGIT;
			end
			S_ZERO: begin
				if (out_free && pad_q == 4'd1) state_d = S_DIGIT;
			end
			S_DIGIT: begin
				if (out_free && nd_q == 4'd1) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		load_in   = 1'b0;
		div_step  = 1'b0;
		size_step = 1'b0;
		emit_fire = 1'b0;
		pad_dec   = 1'b0;
		digit_pop = 1'b0;
		emit_char = CharSpace;
		emit_last = 1'b0;
		unique case (state_q)
			S_IDLE:  load_in = s_tvalid;
			S_FIRST: ;
			S_DIV:   div_step = 1'b1;
			S_SIZE:  size_step = 1'b1;
			S_SPACE: begin
				emit_fire = out_free;
				pad_dec   = out_free;
				emit_char = CharSpace;
			end
			S_SIGN: begin
				emit_fire = out_free;
				emit_char = CharMinus;
			end
			S_ZERO: begin
				emit_fire = out_free;
				pad_dec   = out_free;
				emit_char = CharZero;
			end
			S_DIGIT: begin
				emit_fire = out_free;
				digit_pop = out_free;
				emit_char = digit_char;
				emit_last = (nd_q == 4'd1);
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nd_q       <= '0;
			pad_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_in)        nd_q <= '0;
			else if (div_step)  nd_q <= nd_q + 4'd1;
			else if (digit_pop) nd_q <= nd_q - 4'd1;
			if (size_step)      pad_q <= pad_calc;
			else if (pad_dec)   pad_q <= pad_q - 4'd1;
			if (emit_fire)      m_tvalid_q <= 1'b1;
			else if (m_tready)  m_tvalid_q <= 1'b0;
		end
	end

	// Capture the item; hold the magnitude as unsigned, the most negative fits
	always_ff @(posedge clk) begin
		if (load_in) begin
			neg_q      <= in_value[ValueW-1];
			dividend_q <= in_value[ValueW-1] ? (~in_value + 32'd1) : in_value;
			hex_q      <= s_tdata[32];
			pad_zero_q <= s_tdata[37];
			width_q    <= (in_width > MaxPad) ? MaxPad : in_width;
		end else if (state_q == S_FIRST) begin
			quot_q <= div_out;
		end else if (div_step) begin
			dividend_q <= quot_q;
			quot_q     <= div_out;
		end
	end

	// Digit stack: push least significant first, pop most significant from the top
	always_ff @(posedge clk) begin
		if (div_step) begin
			digit_q[0] <= new_digit;
			for (int i = 1; i < MaxDigits; i++) begin
				digit_q[i] <= digit_q[i-1];
			end
		end else if (digit_pop) begin
			for (int i = 0; i < MaxDigits - 1; i++) begin
				digit_q[i] <= digit_q[i+1];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= emit_char;
			m_tlast_q <= emit_last;
		end
	end

`ifndef NO_ASSERTIONS
	// Accepting an item must leave the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("formatter accepted back to back items");

	// The digit count never passes the stack depth
	assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= CntW'(MaxDigits))
		else $error("digit stack overflow");

	// Digit emission only with digits left
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIGIT |-> nd_q != '0)
		else $error("digit emission with empty stack");

	// Last character returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && emit_last |=> state_q == S_IDLE)
		else $error("sequencer did not finish after last character");
`endif

endmodule
